FILE: hw/rtl/tqs_pkg.sv
`timescale 1ns / 1ps

package tqs_pkg;

  localparam int unsigned DEFAULT_SLOTS = 64;
  localparam int unsigned SLOT_W        = 6;
  localparam int unsigned ID_W          = 16;
  localparam int unsigned DIV_STEPS     = 48;

  localparam logic [15:0] AGING_LIMIT_RST = 16'd8000;
  localparam logic [15:0] LCFS_ABOVE_RST  = 16'd3;
  localparam logic [7:0]  DEF_COEF_RST    = 8'd1;

  typedef enum logic [3:0] {
    K_TICK      = 4'd0,
    K_CREATE    = 4'd1,
    K_PICK      = 4'd2,
    K_YIELD     = 4'd3,
    K_BLOCK     = 4'd4,
    K_WAKE      = 4'd5,
    K_FREE      = 4'd6,
    K_SET_QUEUE = 4'd7,
    K_SET_COEF  = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } rsp_status_e;

  typedef enum logic [1:0] {
    Q_RR    = 2'd0,
    Q_LCFS  = 2'd1,
    Q_MHRRN = 2'd2
  } queue_e;

  // Sub-state of a used entry; an unused entry is marked by its valid bit.
  typedef enum logic [1:0] {
    E_SLEEPING = 2'd0,
    E_RUNNABLE = 2'd1,
    E_RUNNING  = 2'd2
  } est_e;

  typedef enum logic [1:0] {
    CFG_AGING_LIMIT = 2'd0,
    CFG_LCFS_ABOVE  = 2'd1,
    CFG_DEFAULT_COEF = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_DIV,
    S_SCORE,
    S_CHOOSE,
    S_AGE_RD,
    S_AGE_WR,
    S_SLOT_RD,
    S_SLOT_EV,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [5:0]  slot;
    logic [15:0] task_id;
    logic [31:0] channel;
    logic [1:0]  queue_sel;
    logic [7:0]  coef_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  chosen_slot;
    logic [15:0] chosen_id;
  } rsp_t;

  typedef struct packed {
    est_e        st;
    logic [15:0] id;
    queue_e      queue;
    logic [31:0] arrival;
    logic [31:0] turn;
    logic [31:0] runs;
    logic [7:0]  coef;
    logic [15:0] wait_cnt;
    logic [31:0] channel;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

FILE: hw/rtl/tqs_ram.sv
`timescale 1ns / 1ps

module tqs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/three_queue_task_scheduler.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in       request    in_valid_i/in_stall_o  in_req_i   (tqs_pkg::req_t)
// out      response   out_valid_o/out_stall_i out_rsp_o (tqs_pkg::rsp_t)
// cfg      write      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One request is in work at a time; in_stall_o is high from acceptance until
// the response has been moved into the output register.
// A tick or unknown kind goes straight to the response; a slot request reads
// and then updates its slot; create, wake and the id lookups scan the table.
// A pick scans the table, chooses, then runs an aging pass over all slots if
// any candidate was found, and responds; the shared restoring divider runs for
// every runnable entry in the HRRN queue with nonzero wait.
// Reset clears the control state and the per-entry valid bits at once; the
// entry table RAM needs no clearing pass. A stalled response waits in the
// output register while the next request is already taken.

module three_queue_task_scheduler #(
  parameter int unsigned SLOTS = tqs_pkg::DEFAULT_SLOTS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tqs_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tqs_pkg::rsp_t out_rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);

  import tqs_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);

  state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] aging_limit_q, lcfs_above_q;
  logic [7:0]  def_coef_q;

  // Global counters.
  logic [31:0] tick_q;
  logic [15:0] next_id_q;

  // Request being served and its result.
  req_t        req_q;
  rsp_t        res_q;
  logic [IW-1:0] idx_q;
  logic [SLOTS-1:0] used_q;

  // Best candidate of each queue found so far in the pick scan.
  logic          rr_found_q, lc_found_q, mh_found_q;
  logic [31:0]   rr_key_q, lc_key_q, mh_key_q;
  logic [IW-1:0] rr_slot_q, lc_slot_q, mh_slot_q;
  logic [15:0]   rr_id_q, lc_id_q, mh_id_q;
  logic [IW-1:0] pick_slot_q;

  // Shared divider: floor((runs << 16) / wait).
  logic [47:0] div_dnd_q, div_quo_q;
  logic [31:0] div_rem_q, div_den_q;
  logic [5:0]  div_cnt_q;

  // Output register.
  logic out_valid_q;
  rsp_t out_rsp_q;

  // Table RAM.
  logic          ram_we;
  logic [IW-1:0] ram_addr;
  entry_t        ram_wdata, ent;
  logic [ENTRY_W-1:0] ram_rdata;

  tqs_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign ent = entry_t'(ram_rdata);

  // Decoded conditions on the entry under the read port.
  logic          in_acc, out_free, slot_in_range, scan_last, used_c, runnable_c;
  logic          create_hit, find_hit, wake_hit, mh_cand, need_div, slot_ok;
  logic          is_slot_op, is_scan_op, age_promote;
  logic [31:0]   wait_c;
  logic [IW-1:0] slot_idx;
  logic [15:0]   aged_wait;
  queue_e        qsel_sat;
  logic [32:0]   div_trial;
  logic          div_ge;
  logic [48:0]   ratio_c, half_c;
  logic [49:0]   sum_c;
  logic [31:0]   score_c;

  assign in_acc        = in_valid_i && !in_stall_o;
  assign out_free      = !out_valid_q || !out_stall_i;
  assign slot_in_range = 32'(in_req_i.slot) < SLOTS;
  assign slot_idx      = IW'(req_q.slot);
  assign scan_last     = idx_q == IW'(SLOTS - 1);
  assign used_c        = used_q[ram_addr];
  assign runnable_c    = used_c && ent.st == E_RUNNABLE;
  assign wait_c        = tick_q - ent.arrival;
  assign qsel_sat      = (req_q.queue_sel == 2'd3) ? Q_MHRRN : queue_e'(req_q.queue_sel);

  assign create_hit = req_q.kind == K_CREATE && !used_c;
  assign find_hit   = (req_q.kind == K_SET_QUEUE || req_q.kind == K_SET_COEF) && used_c &&
                      ent.id == req_q.task_id;
  assign wake_hit   = req_q.kind == K_WAKE && used_c && ent.st == E_SLEEPING &&
                      ent.channel == req_q.channel;
  assign mh_cand    = req_q.kind == K_PICK && runnable_c && ent.queue == Q_MHRRN;
  assign need_div   = mh_cand && wait_c != 32'd0;
  assign slot_ok    = used_c && (req_q.kind == K_FREE || ent.st == E_RUNNING);

  assign is_slot_op = in_req_i.kind == K_YIELD || in_req_i.kind == K_BLOCK ||
                      in_req_i.kind == K_FREE;
  assign is_scan_op = in_req_i.kind == K_CREATE || in_req_i.kind == K_PICK ||
                      in_req_i.kind == K_WAKE || in_req_i.kind == K_SET_QUEUE ||
                      in_req_i.kind == K_SET_COEF;

  // Aging: the stored wait saturates, and a runnable entry outside round
  // robin that has waited past the limit is promoted with its wait cleared.
  assign aged_wait   = (ent.wait_cnt != 16'hFFFF) ? ent.wait_cnt + 16'd1 : ent.wait_cnt;
  assign age_promote = runnable_c && ent.queue != Q_RR && aged_wait > aging_limit_q;

  // One restoring step of the divider.
  assign div_trial = {div_rem_q, div_dnd_q[47]};
  assign div_ge    = div_trial >= {1'b0, div_den_q};

  // Score = ((1 << 16) + quotient + (coef << 16)) / 2, saturated to 32 bits.
  assign ratio_c = 49'(div_quo_q) + 49'h10000;
  assign sum_c   = 50'(ratio_c) + 50'({ent.coef, 16'h0000});
  assign half_c  = sum_c[49:1];
  assign score_c = (half_c[48:32] != '0) ? 32'hFFFF_FFFF : half_c[31:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (is_scan_op) begin
            state_d = S_SCAN_RD;
          end else if (is_slot_op && slot_in_range) begin
            state_d = S_SLOT_RD;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN_RD: state_d = S_SCAN_EV;
      S_SCAN_EV: begin
        if (create_hit || find_hit) begin
          state_d = S_RESP;
        end else if (need_div) begin
          state_d = S_DIV;
        end else if (scan_last) begin
          state_d = (req_q.kind == K_PICK) ? S_CHOOSE : S_RESP;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_DIV: begin
        if (div_cnt_q == 6'(DIV_STEPS - 1)) begin
          state_d = S_SCORE;
        end
      end
      S_SCORE:  state_d = scan_last ? S_CHOOSE : S_SCAN_RD;
      S_CHOOSE: state_d = (rr_found_q || lc_found_q || mh_found_q) ? S_AGE_RD : S_RESP;
      S_AGE_RD: state_d = S_AGE_WR;
      S_AGE_WR: state_d = scan_last ? S_RESP : S_AGE_RD;
      S_SLOT_RD: state_d = S_SLOT_EV;
      S_SLOT_EV: state_d = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Table port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ent;
    ram_addr  = (state_q == S_SLOT_RD || state_q == S_SLOT_EV) ? slot_idx : idx_q;
    case (state_q)
      S_SCAN_EV: begin
        if (create_hit) begin
          ram_we            = 1'b1;
          ram_wdata.st      = E_RUNNABLE;
          ram_wdata.id      = next_id_q;
          ram_wdata.queue   = (next_id_q > lcfs_above_q) ? Q_LCFS : Q_RR;
          ram_wdata.arrival = tick_q;
          ram_wdata.turn    = tick_q;
          ram_wdata.runs    = 32'd1;
          ram_wdata.coef    = def_coef_q;
          ram_wdata.wait_cnt = 16'd0;
        end else if (find_hit) begin
          ram_we = 1'b1;
          if (req_q.kind == K_SET_QUEUE) begin
            ram_wdata.queue    = qsel_sat;
            ram_wdata.wait_cnt = 16'd0;
          end else begin
            ram_wdata.coef = req_q.coef_value;
          end
        end else if (wake_hit) begin
          ram_we       = 1'b1;
          ram_wdata.st = E_RUNNABLE;
        end
      end
      S_AGE_WR: begin
        ram_we             = 1'b1;
        ram_wdata.wait_cnt = aged_wait;
        if (age_promote) begin
          ram_wdata.queue    = Q_RR;
          ram_wdata.wait_cnt = 16'd0;
        end
        if (idx_q == pick_slot_q) begin
          ram_wdata.st       = E_RUNNING;
          ram_wdata.wait_cnt = 16'd0;
        end
      end
      S_SLOT_EV: begin
        if (slot_ok && req_q.kind == K_YIELD) begin
          ram_we       = 1'b1;
          ram_wdata.st = E_RUNNABLE;
          if (ent.runs != 32'hFFFF_FFFF) begin
            ram_wdata.runs = ent.runs + 32'd1;
          end
          if (ent.queue == Q_RR) begin
            ram_wdata.turn = tick_q;
          end
        end else if (slot_ok && req_q.kind == K_BLOCK) begin
          ram_we            = 1'b1;
          ram_wdata.st      = E_SLEEPING;
          ram_wdata.channel = req_q.channel;
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      aging_limit_q <= AGING_LIMIT_RST;
      lcfs_above_q  <= LCFS_ABOVE_RST;
      def_coef_q    <= DEF_COEF_RST;
      tick_q        <= '0;
      next_id_q     <= 16'd1;
      used_q        <= '0;
      idx_q         <= '0;
      div_cnt_q     <= '0;
      rr_found_q    <= 1'b0;
      lc_found_q    <= 1'b0;
      mh_found_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_AGING_LIMIT:  aging_limit_q <= cfg_data_i;
          CFG_LCFS_ABOVE:   lcfs_above_q  <= cfg_data_i;
          CFG_DEFAULT_COEF: def_coef_q    <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      // In the response state the output register is reloaded below instead.
      if (out_valid_q && !out_stall_i && state_q != S_RESP) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          idx_q      <= '0;
          rr_found_q <= 1'b0;
          lc_found_q <= 1'b0;
          mh_found_q <= 1'b0;
          if (in_acc && in_req_i.kind == K_TICK) begin
            tick_q <= tick_q + 32'd1;
          end
        end
        S_SCAN_EV: begin
          if (create_hit) begin
            used_q[idx_q] <= 1'b1;
            next_id_q     <= next_id_q + 16'd1;
          end
          if (req_q.kind == K_PICK && runnable_c) begin
            if (ent.queue == Q_RR && (!rr_found_q || ent.turn < rr_key_q)) begin
              rr_found_q <= 1'b1;
            end
            if (ent.queue == Q_LCFS && (!lc_found_q || ent.arrival > lc_key_q)) begin
              lc_found_q <= 1'b1;
            end
            if (mh_cand && !need_div) begin
              mh_found_q <= 1'b1;
            end
          end
          if (need_div) begin
            div_cnt_q <= '0;
          end else if (!scan_last) begin
            idx_q <= idx_q + IW'(1);
          end
        end
        S_DIV: div_cnt_q <= div_cnt_q + 6'd1;
        S_SCORE: begin
          if (!mh_found_q || score_c > mh_key_q) begin
            mh_found_q <= 1'b1;
          end
          if (!scan_last) begin
            idx_q <= idx_q + IW'(1);
          end
        end
        S_CHOOSE: idx_q <= '0;
        S_AGE_WR: begin
          if (!scan_last) begin
            idx_q <= idx_q + IW'(1);
          end
        end
        S_SLOT_EV: begin
          if (slot_ok && req_q.kind == K_FREE) begin
            used_q[slot_idx] <= 1'b0;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_q <= in_req_i;
          res_q <= '{status: (is_slot_op && !slot_in_range) ? STAT_NOT_FOUND : STAT_DONE,
                     chosen_slot: '0, chosen_id: '0};
        end
      end
      S_SCAN_EV: begin
        if (create_hit) begin
          res_q.chosen_slot <= SLOT_W'(idx_q);
          res_q.chosen_id   <= next_id_q;
        end else if (!find_hit && !need_div && scan_last) begin
          if (req_q.kind == K_CREATE) begin
            res_q.status <= STAT_EMPTY;
          end else if (req_q.kind == K_SET_QUEUE || req_q.kind == K_SET_COEF) begin
            res_q.status <= STAT_NOT_FOUND;
          end
        end
        if (req_q.kind == K_PICK && runnable_c) begin
          if (ent.queue == Q_RR && (!rr_found_q || ent.turn < rr_key_q)) begin
            rr_key_q  <= ent.turn;
            rr_slot_q <= idx_q;
            rr_id_q   <= ent.id;
          end
          if (ent.queue == Q_LCFS && (!lc_found_q || ent.arrival > lc_key_q)) begin
            lc_key_q  <= ent.arrival;
            lc_slot_q <= idx_q;
            lc_id_q   <= ent.id;
          end
          if (mh_cand && !need_div && (!mh_found_q || mh_key_q != 32'hFFFF_FFFF)) begin
            mh_key_q  <= 32'hFFFF_FFFF;
            mh_slot_q <= idx_q;
            mh_id_q   <= ent.id;
          end
        end
        if (need_div) begin
          div_dnd_q <= {ent.runs, 16'h0000};
          div_den_q <= wait_c;
          div_rem_q <= '0;
          div_quo_q <= '0;
        end
      end
      S_DIV: begin
        div_dnd_q <= {div_dnd_q[46:0], 1'b0};
        div_quo_q <= {div_quo_q[46:0], div_ge};
        div_rem_q <= div_ge ? 32'(div_trial - {1'b0, div_den_q}) : div_trial[31:0];
      end
      S_SCORE: begin
        if (!mh_found_q || score_c > mh_key_q) begin
          mh_key_q  <= score_c;
          mh_slot_q <= idx_q;
          mh_id_q   <= ent.id;
        end
      end
      S_CHOOSE: begin
        if (rr_found_q) begin
          pick_slot_q       <= rr_slot_q;
          res_q.chosen_slot <= SLOT_W'(rr_slot_q);
          res_q.chosen_id   <= rr_id_q;
        end else if (lc_found_q) begin
          pick_slot_q       <= lc_slot_q;
          res_q.chosen_slot <= SLOT_W'(lc_slot_q);
          res_q.chosen_id   <= lc_id_q;
        end else if (mh_found_q) begin
          pick_slot_q       <= mh_slot_q;
          res_q.chosen_slot <= SLOT_W'(mh_slot_q);
          res_q.chosen_id   <= mh_id_q;
        end else begin
          res_q.status <= STAT_EMPTY;
        end
      end
      S_SLOT_EV: begin
        if (!slot_ok) begin
          res_q.status <= STAT_NOT_FOUND;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_rsp_q <= res_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;
  assign cfg_ready_o = 1'b1;

  // A request that is taken blocks the input until its response is queued.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled after a request was taken");

  // The table is written only by the states that update an entry.
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_SCAN_EV || state_q == S_AGE_WR || state_q == S_SLOT_EV))
    else $error("table written outside an update state");

  // A new response appears only after the response state handed it over.
  a_resp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("response raised outside the response state");

  // The divider never runs past its step count.
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> div_cnt_q < 6'(DIV_STEPS))
    else $error("divider step count overrun");

  // The aging pass runs only when some candidate was found.
  a_age_has_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHOOSE && state_d == S_AGE_RD) |-> (rr_found_q || lc_found_q || mh_found_q))
    else $error("aging pass without a chosen entry");

endmodule
